// File: src/pdb_pkg.sv
// Shared types and constants for the PCM double-buffer DAC player.
`default_nettype none
package pdb_pkg;

	localparam int SAMPLE_W = 32;
	localparam int LEVEL_W = 8;
	localparam int RATE_W = 3;
	localparam int STEP_W = 32;
	localparam int OUT_W = 16;
	localparam int RATE_COUNT = 5;

	// Sample periods in picoseconds for 8000, 11025, 22050, 44100 and 48000 Hz
	localparam logic [31:0] PERIOD_PS [RATE_COUNT] = '{
		32'd125000000, 32'd90702948, 32'd45351474, 32'd22675737, 32'd20833333
	};

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_RATE_SELECT = 1'b0,
		REG_TICK_STEP   = 1'b1
	} pdb_reg_t;

	// Item kinds carried on tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Per-item control passed from the state update to the output stage
	typedef struct packed {
		logic strobe;
		logic load;
		logic done;
		logic may_fill;
	} pdb_ctl_t;

endpackage
`default_nettype wire

// File: src/pcm_double_buffer_dac_player_unit.sv
// Top level of the PCM double-buffer DAC player.
// Samples (op 0) are quantized to 8-bit offset values and written into one of
// two frame banks in a single store of 2*FRAME_SAMPLES bytes; a frame-end mark
// swaps banks and starts playback. Ticks (op 1) advance the phase accumulator
// and, once it passes the selected sample period, read the next byte for the
// DAC. Every item gives exactly one result. One item is accepted per clock
// while the output is not stalled; the result passes through the store's
// registered read and then the output register. The store is not cleared at reset.
`default_nettype none
module pcm_double_buffer_dac_player_unit #(
	parameter int FRAME_SAMPLES = 1152,
	parameter int FRACTION_BITS = 28
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sample_value
	input  wire logic        s_tuser,   // op
	input  wire logic        s_tlast,   // frame_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] dac_strobe, [8:1] dac_level, [9] buffer_done, [10] writer_may_fill
	output logic      [15:0] m_tdata
);

	localparam int DEPTH = 2 * FRAME_SAMPLES;
	localparam int AW = $clog2(DEPTH);

	logic                         accept;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [pdb_pkg::LEVEL_W-1:0]  wr_data;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [pdb_pkg::LEVEL_W-1:0]  rd_data;
	pdb_pkg::pdb_ctl_t            ctl;

	assign cfg_ready = 1'b1;
	assign accept = s_tvalid & s_tready;

	pdb_ctrl #(
		.FRAME_SAMPLES(FRAME_SAMPLES),
		.FRACTION_BITS(FRACTION_BITS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.op(s_tuser),
		.sample_value(s_tdata),
		.frame_end(s_tlast),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.ctl(ctl)
	);

	pdb_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pdb_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.ctl(ctl),
		.rd_data(rd_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

	a_done_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9]) |-> m_tdata[0])
		else $error("buffer done reported without a DAC strobe");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

endmodule
`default_nettype wire

// File: src/pdb_store.sv
// Two-bank frame store: one write port, one registered read port.
`default_nettype none
module pdb_store #(
	parameter int DEPTH = 2304,
	parameter int AW = 12
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [pdb_pkg::LEVEL_W-1:0]  wr_data,
	input  wire logic                         rd_en,
	input  wire logic [AW-1:0]                rd_addr,
	output logic      [pdb_pkg::LEVEL_W-1:0]  rd_data
);

	logic [pdb_pkg::LEVEL_W-1:0] mem [DEPTH];
	logic [pdb_pkg::LEVEL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold the read data until the next read so a stalled output keeps it
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: src/pdb_ctrl.sv
// Writer/player state: quantizer, bank and slot pointers, phase accumulator.
`default_nettype none
module pdb_ctrl #(
	parameter int FRAME_SAMPLES = 1152,
	parameter int FRACTION_BITS = 28,
	parameter int AW = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [31:0]                   cfg_data,
	input  wire logic                          accept,
	input  wire logic                          op,
	input  wire logic [pdb_pkg::SAMPLE_W-1:0]  sample_value,
	input  wire logic                          frame_end,
	output logic                               wr_en,
	output logic      [AW-1:0]                 wr_addr,
	output logic      [pdb_pkg::LEVEL_W-1:0]   wr_data,
	output logic                               rd_en,
	output logic      [AW-1:0]                 rd_addr,
	output pdb_pkg::pdb_ctl_t                  ctl
);

	localparam int SW = $clog2(FRAME_SAMPLES + 1);
	localparam logic [SW-1:0] FS_C = SW'(FRAME_SAMPLES);
	localparam logic [AW-1:0] BANK1_BASE = AW'(FRAME_SAMPLES);
	localparam logic signed [32:0] ONE = 33'sd1 <<< FRACTION_BITS;
	localparam logic signed [32:0] HALF_LSB = 33'sd1 <<< (FRACTION_BITS - 8);

	logic [pdb_pkg::RATE_W-1:0] rate_sel_q;
	logic [pdb_pkg::STEP_W-1:0] tick_step_q;
	logic [SW-1:0]              frame_len_q [2];
	logic [SW-1:0]              wslot_q, wslot_d;
	logic                       wbank_q, wbank_d;
	logic [SW-1:0]              rslot_q, rslot_d;
	logic                       rbank_q, rbank_d;
	logic [31:0]                phase_q, phase_d;
	logic                       playing_q, playing_d;
	logic                       wait_q, wait_d;
	logic                       claim_q, claim_d;
	logic                       len_we;

	logic [31:0]                period;
	logic [SW-1:0]              wslot_inc;
	logic [SW-1:0]              rslot_inc;
	logic                       fire;
	logic                       bank_end;
	logic signed [32:0]         s_rnd;
	logic signed [32:0]         s_clp;
	logic [32:0]                s_off;
	logic [pdb_pkg::LEVEL_W-1:0] q_raw;

	// Round, clip to [-1, 1), offset, keep the top 8 bits and subtract one, floored at zero
	always_comb begin
		s_rnd = {sample_value[pdb_pkg::SAMPLE_W-1], sample_value} + HALF_LSB;
		if (s_rnd >= ONE) begin
			s_clp = ONE - 33'sd1;
		end else if (s_rnd < -ONE) begin
			s_clp = -ONE;
		end else begin
			s_clp = s_rnd;
		end
		s_off = 33'(s_clp + ONE);
		q_raw = s_off[FRACTION_BITS -: 8];
		wr_data = (q_raw == '0) ? '0 : q_raw - 8'd1;
	end

	assign period = (rate_sel_q < pdb_pkg::RATE_W'(pdb_pkg::RATE_COUNT)) ?
		pdb_pkg::PERIOD_PS[rate_sel_q] : pdb_pkg::PERIOD_PS[0];
	assign wslot_inc = wslot_q + SW'(1);
	assign rslot_inc = rslot_q + SW'(1);
	assign fire = (phase_q > period);
	assign bank_end = (rslot_inc >= frame_len_q[rbank_q]);

	assign wr_addr = wbank_q ? BANK1_BASE + AW'(wslot_q) : AW'(wslot_q);
	assign rd_addr = rbank_q ? BANK1_BASE + AW'(rslot_q) : AW'(rslot_q);

	always_comb begin
		wslot_d = wslot_q;
		wbank_d = wbank_q;
		rslot_d = rslot_q;
		rbank_d = rbank_q;
		phase_d = phase_q;
		playing_d = playing_q;
		wait_d = wait_q;
		claim_d = claim_q;
		len_we = 1'b0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		ctl = '0;
		if (accept) begin
			if (op == pdb_pkg::OP_SAMPLE) begin
				if (!claim_q) begin
					if (wslot_q < FS_C) begin
						wr_en = 1'b1;
						wslot_d = wslot_inc;
					end
					if (frame_end) begin
						len_we = 1'b1;
						wslot_d = '0;
						wbank_d = ~wbank_q;
						playing_d = 1'b1;
						if (wait_q) begin
							claim_d = 1'b1;
						end else begin
							wait_d = 1'b1;
						end
					end
				end
			end else if (playing_q) begin
				if (fire) begin
					phase_d = phase_q - period;
					rd_en = 1'b1;
					ctl.strobe = 1'b1;
					ctl.load = (rslot_q < FS_C);
					rslot_d = rslot_inc;
					if (bank_end) begin
						rslot_d = '0;
						rbank_d = ~rbank_q;
						ctl.done = 1'b1;
						// release, and hand the flag straight to a pending claim
						wait_d = claim_q;
						claim_d = 1'b0;
					end
				end else begin
					phase_d = phase_q + tick_step_q;
				end
			end
		end
		ctl.may_fill = ~claim_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_sel_q <= '0;
			tick_step_q <= '0;
		end else if (cfg_valid) begin
			unique case (pdb_pkg::pdb_reg_t'(cfg_index))
				pdb_pkg::REG_RATE_SELECT: rate_sel_q <= cfg_data[pdb_pkg::RATE_W-1:0];
				pdb_pkg::REG_TICK_STEP:   tick_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q[0] <= '0;
			frame_len_q[1] <= '0;
			wslot_q <= '0;
			wbank_q <= 1'b0;
			rslot_q <= '0;
			rbank_q <= 1'b0;
			phase_q <= '0;
			playing_q <= 1'b0;
			wait_q <= 1'b0;
			claim_q <= 1'b0;
		end else begin
			if (len_we) begin
				frame_len_q[wbank_q] <= wr_en ? wslot_inc : wslot_q;
			end
			wslot_q <= wslot_d;
			wbank_q <= wbank_d;
			rslot_q <= rslot_d;
			rbank_q <= rbank_d;
			phase_q <= phase_d;
			playing_q <= playing_d;
			wait_q <= wait_d;
			claim_q <= claim_d;
		end
	end

	a_claim_needs_wait: assert property (@(posedge clk) disable iff (!arst_n)
		claim_q |-> wait_q)
		else $error("claim pending without the wait flag held");

	a_rslot_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rslot_q < FS_C)
		else $error("read slot past the frame");

endmodule
`default_nettype wire

// File: src/pdb_out.sv
// Result stage: merges store read data into the DAC hold and drives the output register.
`default_nettype none
module pdb_out (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire pdb_pkg::pdb_ctl_t             ctl,
	input  wire logic [pdb_pkg::LEVEL_W-1:0]   rd_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [pdb_pkg::OUT_W-1:0]     out_data
);

	logic                        s1_valid_q;
	pdb_pkg::pdb_ctl_t           ctl_s1;
	logic                        out_valid_q;
	logic [pdb_pkg::OUT_W-1:0]   out_data_q;
	logic [pdb_pkg::LEVEL_W-1:0] hold_q;
	logic [pdb_pkg::LEVEL_W-1:0] level;
	logic                        s1_adv;

	assign s1_adv = s1_valid_q & (~out_valid_q | out_ready);
	assign in_ready = ~s1_valid_q | s1_adv;
	assign level = ctl_s1.load ? rd_data : hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			hold_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				hold_q <= level;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ctl_s1 <= ctl;
		end
		if (s1_adv) begin
			out_data_q <= {5'd0, ctl_s1.may_fill, ctl_s1.done, level, ctl_s1.strobe};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking regression for the PCM double-buffer DAC player: stream stimulus, local predictor.
`default_nettype none
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN = 1152;
	localparam int FRAC_W = 28;
	localparam logic [31:0] RATE_PERIOD [5] = '{
		32'd125000000, 32'd90702948, 32'd45351474, 32'd22675737, 32'd20833333
	};
	localparam logic [31:0] EDGE_SAMPLES [9] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hF000_0000, 32'h1000_0000,
		32'h0FFF_FFFF, 32'hF020_0000, 32'h0010_0000, 32'hFFF0_0000
	};

	// Field order matches m_tdata[10:0]
	typedef struct packed {
		logic       may_fill;
		logic       done;
		logic [7:0] level;
		logic       strobe;
	} dac_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] sample_value
	logic        s_tuser;   // op
	logic        s_tlast;   // frame_end
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [0] dac_strobe, [8:1] dac_level, [9] buffer_done, [10] writer_may_fill

	// Predicted player state
	logic [2:0]  rate_sel;
	logic [31:0] step_ps;
	logic [7:0]  bank_bytes [2*FRAME_LEN];
	bit          bank_written [2*FRAME_LEN];
	int unsigned bank_len [2];
	int unsigned fill_slot;
	int unsigned play_slot;
	bit          fill_bank;
	bit          play_bank;
	logic [31:0] phase_ps;
	bit          playing;
	bit          wait_flag;
	bit          claim_pending;
	logic [7:0]  level_hold;

	dac_result_t expected_dac_q [$];
	dac_result_t want_dac;
	dac_result_t got_dac;
	bit          src_gaps;
	bit          sink_gaps;
	int          sink_hold_cycles;
	int          mismatch_count;
	int          items_sent;
	int          results_checked;
	int          strobes_seen;
	int          banks_done;

	pcm_double_buffer_dac_player_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [7:0] quantize_level(logic [31:0] raw);
		longint one;
		longint s;
		longint q;
		one = longint'(1) << FRAC_W;
		s = longint'($signed(raw));
		s += longint'(1) << (FRAC_W - 8);
		if (s >= one)
			s = one - 1;
		else if (s < -one)
			s = -one;
		q = ((s + one) >>> (FRAC_W - 7)) - 1;
		// floor the most negative samples at 0 instead of wrapping
		if (q < 0)
			q = 0;
		if (q > 255)
			q = 255;
		return q[7:0];
	endfunction

	function automatic dac_result_t advance_player(logic op, logic [31:0] value, logic last_mark);
		dac_result_t r;
		logic [31:0] period;
		int          idx;
		r.strobe = 1'b0;
		r.done = 1'b0;
		if (op == pdb_pkg::OP_SAMPLE) begin
			if (!claim_pending) begin
				if (fill_slot < FRAME_LEN) begin
					idx = int'(fill_bank) * FRAME_LEN + fill_slot;
					bank_bytes[idx] = quantize_level(value);
					bank_written[idx] = 1'b1;
					fill_slot++;
				end
				if (last_mark) begin
					bank_len[fill_bank] = fill_slot;
					fill_slot = 0;
					fill_bank = ~fill_bank;
					playing = 1'b1;
					if (wait_flag)
						claim_pending = 1'b1;
					else
						wait_flag = 1'b1;
				end
			end
		end else if (playing) begin
			period = RATE_PERIOD[rate_sel < 5 ? rate_sel : 0];
			if (phase_ps > period) begin
				phase_ps -= period;
				if (play_slot < FRAME_LEN)
					level_hold = bank_bytes[int'(play_bank) * FRAME_LEN + play_slot];
				r.strobe = 1'b1;
				play_slot++;
				if (play_slot >= bank_len[play_bank]) begin
					play_slot = 0;
					play_bank = ~play_bank;
					r.done = 1'b1;
					wait_flag = 1'b0;
					// a pending claim takes the flag as soon as it is released
					if (claim_pending) begin
						claim_pending = 1'b0;
						wait_flag = 1'b1;
					end
				end
			end else begin
				phase_ps += step_ps;
			end
		end
		r.level = level_hold;
		r.may_fill = !claim_pending;
		return r;
	endfunction

	// True when the next tick would drive a store entry that was never filled
	function automatic bit tick_hits_unwritten();
		logic [31:0] period;
		period = RATE_PERIOD[rate_sel < 5 ? rate_sel : 0];
		if (!playing || phase_ps <= period || play_slot >= FRAME_LEN)
			return 1'b0;
		return !bank_written[int'(play_bank) * FRAME_LEN + play_slot];
	endfunction

	function automatic logic [31:0] pick_sample();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return $urandom;
		else if (pick < 80)
			return $urandom_range(32'h1FFF_FFFF) - 32'h1000_0000;
		return $urandom_range(32'h003F_FFFF) - 32'h0020_0000;
	endfunction

	task automatic send_item(input logic op, input logic [31:0] value, input logic last_mark);
		dac_result_t predicted;
		@(negedge clk);
		while (src_gaps && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		s_tlast <= last_mark;
		predicted = advance_player(op, value, last_mark);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_dac_q.push_back(predicted);
		items_sent++;
	endtask

	task automatic wait_player_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_dac_q.size() != 0)
			@(posedge clk);
		// output register plus store read
		repeat (4) @(posedge clk);
	endtask

	task automatic write_player_reg(input pdb_pkg::pdb_reg_t idx, input logic [31:0] data);
		wait_player_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			pdb_pkg::REG_RATE_SELECT: rate_sel = data[2:0];
			pdb_pkg::REG_TICK_STEP:   step_ps = data;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count, input bit gaps);
		int   taken;
		logic op;
		logic last_mark;
		src_gaps = gaps;
		sink_gaps = gaps;
		taken = 0;
		while (taken < count) begin
			op = ($urandom_range(99) < 55) ? pdb_pkg::OP_TICK : pdb_pkg::OP_SAMPLE;
			// a blocked writer mostly waits, but sometimes pushes anyway
			if (op == pdb_pkg::OP_SAMPLE && claim_pending && $urandom_range(9) != 0)
				op = pdb_pkg::OP_TICK;
			if (op == pdb_pkg::OP_TICK && tick_hits_unwritten())
				op = pdb_pkg::OP_SAMPLE;
			last_mark = ($urandom_range(5) == 0);
			if (!(op == pdb_pkg::OP_SAMPLE && claim_pending))
				taken++;
			send_item(op, pick_sample(), last_mark);
		end
	endtask

	task automatic test_idle_ticks();
		repeat (2) send_item(pdb_pkg::OP_TICK, $urandom, 1'b1);
	endtask

	task automatic test_quantizer_frame();
		foreach (EDGE_SAMPLES[i])
			send_item(pdb_pkg::OP_SAMPLE, EDGE_SAMPLES[i], i == 8);
		// first entry of the second bank, with no frame-end mark
		send_item(pdb_pkg::OP_SAMPLE, 32'h5A5A_5A5A, 1'b0);
	endtask

	task automatic test_blocked_writer();
		send_item(pdb_pkg::OP_SAMPLE, 32'hC000_0000, 1'b1);
		send_item(pdb_pkg::OP_SAMPLE, 32'h3000_0000, 1'b1);
		send_item(pdb_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0);
	endtask

	task automatic test_accumulator_wrap();
		write_player_reg(pdb_pkg::REG_RATE_SELECT, 32'd7);
		write_player_reg(pdb_pkg::REG_TICK_STEP, 32'hFFFF_FFFF);
		repeat (12) send_item(pdb_pkg::OP_TICK, $urandom, $urandom_range(1));
	endtask

	task automatic test_random_play();
		write_player_reg(pdb_pkg::REG_RATE_SELECT, 32'd3);
		write_player_reg(pdb_pkg::REG_TICK_STEP, 32'h0100_0000);
		run_random(75, 1'b0);
		write_player_reg(pdb_pkg::REG_RATE_SELECT, 32'd4);
		write_player_reg(pdb_pkg::REG_TICK_STEP, $urandom_range(50000000, 10000000));
		run_random(75, 1'b1);
		write_player_reg(pdb_pkg::REG_RATE_SELECT, {29'h1FFF_FFFF, 3'd5});
		write_player_reg(pdb_pkg::REG_TICK_STEP, $urandom);
		run_random(75, 1'b1);
		write_player_reg(pdb_pkg::REG_RATE_SELECT, 32'd1);
		write_player_reg(pdb_pkg::REG_TICK_STEP, 32'h8000_0000);
		run_random(75, 1'b1);
	endtask

	task automatic test_backpressure();
		// step equal to the period: the accumulator must pass it, not reach it
		write_player_reg(pdb_pkg::REG_RATE_SELECT, 32'd0);
		write_player_reg(pdb_pkg::REG_TICK_STEP, 32'd125000000);
		@(posedge clk);
		sink_hold_cycles = 80;
		run_random(60, 1'b0);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_dac = dac_result_t'(m_tdata[10:0]);
			if (expected_dac_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected DAC result %h", m_tdata);
			end else begin
				want_dac = expected_dac_q.pop_front();
				results_checked++;
				strobes_seen += want_dac.strobe;
				banks_done += want_dac.done;
				if (got_dac.strobe !== want_dac.strobe || got_dac.level !== want_dac.level ||
						got_dac.done !== want_dac.done || got_dac.may_fill !== want_dac.may_fill) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: expected strobe=%0b level=%0d done=%0b may_fill=%0b,%s",
							results_checked, want_dac.strobe, want_dac.level, want_dac.done,
							want_dac.may_fill, $sformatf(" got strobe=%0b level=%0d done=%0b may_fill=%0b",
							got_dac.strobe, got_dac.level, got_dac.done, got_dac.may_fill));
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles > 0) begin
				m_tready <= 1'b0;
				sink_hold_cycles--;
			end else begin
				m_tready <= !(sink_gaps && $urandom_range(99) < 26);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("pcm_double_buffer_dac_player_unit regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pdb_pkg::REG_RATE_SELECT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pdb_pkg::OP_SAMPLE;
		s_tlast = 1'b0;
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		rate_sel = '0;
		step_ps = '0;
		phase_ps = '0;
		level_hold = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_ticks();
		test_quantizer_frame();
		test_blocked_writer();
		test_accumulator_wrap();
		test_random_play();
		test_backpressure();
		wait_player_idle();

		mismatch_count += expected_dac_q.size();
		$display("%0d items sent, %0d results checked, %0d DAC strobes, %0d banks played out",
			items_sent, results_checked, strobes_seen, banks_done);
		$display("rate selects 0, 1, 3, 4 and out of range, steps 0 to max, blocked writer, long stall");
		if (mismatch_count == 0)
			$display("pcm_double_buffer_dac_player_unit regression: pass");
		else
			$display("pcm_double_buffer_dac_player_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
